/* hw/rtl/mse_pkg.sv */
// Shared constants, types and codes of the multi-stack move engine.
package mse_pkg;

    // Geometry of the stack store
    localparam int NUM_STACKS  = 16;
    localparam int STACK_DEPTH = 64;

    localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int HGT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_STACKS * STACK_DEPTH);
    localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int IDX_W   = 4;
    localparam int ERR_W   = 2;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HSRC,
        S_HDST,
        S_COPY,
        S_REPORT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [BYTE_W-1:0]  item;
        logic [COUNT_W-1:0] count;
        logic [IDX_W-1:0]   source_stack;
        logic [IDX_W-1:0]   dest_stack;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] top_item;
        logic              is_empty;
        t_err              error_code;
    } t_rsp;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_cmd;

endpackage

/* hw/rtl/mse_ram.sv */
// Byte store holding all stacks: one write port, one registered read port.
module mse_ram (
    input  logic                  i_clk,
    input  mse_pkg::t_ram_cmd     i_cmd,
    output logic [mse_pkg::BYTE_W-1:0] o_rdata
);

    logic [mse_pkg::BYTE_W-1:0] r_mem [mse_pkg::MEM_DEPTH];
    logic [mse_pkg::BYTE_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_cmd.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/mse_ctrl.sv */
// Sequencer: height table, bounds checks and the item-by-item copy loop.
module mse_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  mse_pkg::t_req              i_req,
    input  logic                       i_keep_order,
    input  logic                       i_out_free,
    output logic                       o_idle,
    output logic                       o_done,
    output mse_pkg::t_rsp              o_rsp,
    output mse_pkg::t_ram_cmd          o_ram,
    input  logic [mse_pkg::BYTE_W-1:0] i_ram_rdata
);

    localparam int HW = mse_pkg::HGT_W;
    localparam int AW = mse_pkg::ADDR_W;
    localparam int SW = mse_pkg::STK_W;

    mse_pkg::t_state r_state, n_state;
    mse_pkg::t_req   r_req, n_req;
    mse_pkg::t_err   r_err, n_err;

    logic [HW-1:0] r_height [mse_pkg::NUM_STACKS];
    logic [SW-1:0] r_hidx, n_hidx;
    logic [HW-1:0] r_hs, n_hs;
    logic [HW-1:0] r_hd, n_hd;
    logic [AW-1:0] r_src_base, n_src_base;
    logic [AW-1:0] r_dst_base, n_dst_base;
    logic [HW-1:0] r_rd_ptr, n_rd_ptr;
    logic [HW-1:0] r_wr_ptr, n_wr_ptr;
    logic [HW-1:0] r_rd_left, n_rd_left;
    logic          r_wr_pend, n_wr_pend;

    logic          src_ok, dst_ok;
    logic [SW-1:0] src_idx, dst_idx;
    logic [HW-1:0] h_rd, hd_c;
    logic [AW-1:0] dst_base_c;
    logic          hs_we, hd_we;
    logic [HW-1:0] hs_wval, hd_wval;

    assign src_ok  = 32'(r_req.source_stack) < mse_pkg::NUM_STACKS;
    assign dst_ok  = 32'(r_req.dest_stack) < mse_pkg::NUM_STACKS;
    assign src_idx = SW'(r_req.source_stack);
    assign dst_idx = SW'(r_req.dest_stack);

    // Single read port into the height table
    assign h_rd       = r_height[r_hidx];
    assign hd_c       = dst_ok ? h_rd : '0;
    assign dst_base_c = AW'(r_req.dest_stack) * AW'(mse_pkg::STACK_DEPTH);

    // Next state, copy loop and memory port
    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_err      = r_err;
        n_hidx     = r_hidx;
        n_hs       = r_hs;
        n_hd       = r_hd;
        n_src_base = r_src_base;
        n_dst_base = r_dst_base;
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_rd_left  = r_rd_left;
        n_wr_pend  = r_wr_pend;
        hs_we      = 1'b0;
        hd_we      = 1'b0;
        hs_wval    = r_hs - HW'(r_req.count);
        hd_wval    = r_hd + HW'(r_req.count);
        o_done     = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_dst_base + AW'(r_wr_ptr);
        o_ram.wdata = i_ram_rdata;
        // top of destination unless the copy loop owns the read port
        o_ram.raddr = r_dst_base + AW'(r_hd) - AW'(1);

        case (r_state)
            mse_pkg::S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_hidx  = SW'(i_req.source_stack);
                    n_err   = mse_pkg::ERR_OK;
                    n_state = mse_pkg::S_HSRC;
                end
            end

            mse_pkg::S_HSRC: begin
                n_hs       = src_ok ? h_rd : '0;
                n_hidx     = dst_idx;
                n_src_base = AW'(r_req.source_stack) * AW'(mse_pkg::STACK_DEPTH);
                n_state    = mse_pkg::S_HDST;
            end

            mse_pkg::S_HDST: begin
                n_hd       = hd_c;
                n_dst_base = dst_base_c;
                n_state    = mse_pkg::S_REPORT;
                case (r_req.command)
                    mse_pkg::CMD_PUSH: begin
                        if (!dst_ok || 32'(hd_c) >= mse_pkg::STACK_DEPTH) begin
                            n_err = mse_pkg::ERR_OVERFLOW;
                        end else begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = dst_base_c + AW'(hd_c);
                            o_ram.wdata = r_req.item;
                            hd_we       = 1'b1;
                            hd_wval     = hd_c + HW'(1);
                            n_hd        = hd_c + HW'(1);
                        end
                    end
                    mse_pkg::CMD_MOVE: begin
                        if (32'(r_req.count) > 32'(r_hs)) begin
                            n_err = mse_pkg::ERR_UNDERFLOW;
                        end else if (r_req.count == '0 ||
                                     r_req.source_stack == r_req.dest_stack) begin
                            n_err = mse_pkg::ERR_OK;
                        end else if (!dst_ok || 32'(hd_c) + 32'(r_req.count) >
                                     mse_pkg::STACK_DEPTH) begin
                            n_err = mse_pkg::ERR_OVERFLOW;
                        end else begin
                            // block move starts at the group's bottom, reversing one at its top
                            n_rd_ptr  = i_keep_order ? (r_hs - HW'(r_req.count))
                                                     : (r_hs - HW'(1));
                            n_wr_ptr  = hd_c;
                            n_rd_left = HW'(r_req.count);
                            n_wr_pend = 1'b0;
                            n_state   = mse_pkg::S_COPY;
                        end
                    end
                    default: begin
                        n_err = mse_pkg::ERR_OK;
                    end
                endcase
            end

            mse_pkg::S_COPY: begin
                // issue next read while writing the byte read last cycle
                o_ram.raddr = r_src_base + AW'(r_rd_ptr);
                n_wr_pend   = (r_rd_left != '0);
                if (r_rd_left != '0) begin
                    n_rd_left = r_rd_left - HW'(1);
                    n_rd_ptr  = i_keep_order ? (r_rd_ptr + HW'(1)) : (r_rd_ptr - HW'(1));
                end
                if (r_wr_pend) begin
                    o_ram.we = 1'b1;
                    n_wr_ptr = r_wr_ptr + HW'(1);
                end
                if (r_wr_pend && r_rd_left == '0) begin
                    hs_we   = 1'b1;
                    hd_we   = 1'b1;
                    n_hd    = r_hd + HW'(r_req.count);
                    n_state = mse_pkg::S_REPORT;
                end
            end

            mse_pkg::S_REPORT: begin
                // wait for the top byte read
                n_state = mse_pkg::S_DONE;
            end

            mse_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = mse_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = mse_pkg::S_IDLE;
            end
        endcase
    end

    assign o_idle           = (r_state == mse_pkg::S_IDLE);
    assign o_rsp.top_item   = (r_hd == '0) ? '0 : i_ram_rdata;
    assign o_rsp.is_empty   = (r_hd == '0);
    assign o_rsp.error_code = r_err;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mse_pkg::S_IDLE;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_pend <= n_wr_pend;
        end
    end

    // Height table, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mse_pkg::NUM_STACKS; k++) begin
                r_height[k] <= '0;
            end
        end else begin
            if (hs_we) begin
                r_height[src_idx] <= hs_wval;
            end
            if (hd_we) begin
                r_height[dst_idx] <= hd_wval;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_err      <= n_err;
        r_hidx     <= n_hidx;
        r_hs       <= n_hs;
        r_hd       <= n_hd;
        r_src_base <= n_src_base;
        r_dst_base <= n_dst_base;
        r_rd_ptr   <= n_rd_ptr;
        r_wr_ptr   <= n_wr_ptr;
        r_rd_left  <= n_rd_left;
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == mse_pkg::S_IDLE))
        else $error("item started while sequencer busy");

    a_wr_in_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mse_pkg::S_COPY && r_wr_pend) |-> (32'(r_wr_ptr) < mse_pkg::STACK_DEPTH))
        else $error("copy writes past destination stack");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.is_empty) |-> (o_rsp.top_item == '0))
        else $error("empty stack reports nonzero top");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == mse_pkg::S_IDLE))
        else $error("sequencer did not return to idle after result");

endmodule

/* hw/rtl/multi_stack_move_engine.sv */
// Top level of the multi-stack move engine: stream ports, mode register, result register.
//
// Sixteen byte stacks of 64 entries share one single-port-write, single-port-read
// byte memory; the engine works on one item at a time and drops s_axis_tready
// until that item's result has been handed to the output register. A move that is
// neither errored nor a no-op runs a copy loop that moves one byte per cycle
// through the memory's read and write ports. The result register lets the next
// item be accepted while the previous result waits. keep_order is written through
// i_cfg_wr_en/i_cfg_wr_data and must only change while the engine is idle.
module multi_stack_move_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item[7:0], count[14:8], source_stack[18:15], dest_stack[22:19]
    input  logic [mse_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // command[1:0]
    input  logic [mse_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // top_item[7:0], is_empty[8], error_code[10:9]
    output logic [mse_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_wr_data
);

    mse_pkg::t_req     req;
    mse_pkg::t_rsp     rsp;
    mse_pkg::t_ram_cmd ram_cmd;
    logic [mse_pkg::BYTE_W-1:0] ram_rdata;
    logic              ctrl_idle, ctrl_done, start, out_free;

    logic          r_keep_order;
    logic          r_out_vld;
    mse_pkg::t_rsp r_out;

    // Unpack the input item
    assign req.command      = i_s_axis_tuser;
    assign req.item         = i_s_axis_tdata[7:0];
    assign req.count        = i_s_axis_tdata[14:8];
    assign req.source_stack = i_s_axis_tdata[18:15];
    assign req.dest_stack   = i_s_axis_tdata[22:19];

    assign o_s_axis_tready = ctrl_idle;
    assign start           = i_s_axis_tvalid && ctrl_idle;
    assign out_free        = !r_out_vld || i_m_axis_tready;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_order <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_keep_order <= i_cfg_wr_data;
        end
    end

    // Result register: load on done, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ctrl_done) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_done) begin
            r_out <= rsp;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'b0, r_out.error_code, r_out.is_empty, r_out.top_item};

    mse_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req        (req),
        .i_keep_order (r_keep_order),
        .i_out_free   (out_free),
        .o_idle       (ctrl_idle),
        .o_done       (ctrl_done),
        .o_rsp        (rsp),
        .o_ram        (ram_cmd),
        .i_ram_rdata  (ram_rdata)
    );

    mse_ram u_ram (
        .i_clk   (i_clk),
        .i_cmd   (ram_cmd),
        .o_rdata (ram_rdata)
    );

endmodule

/* tb/sv/multi_stack_move_engine_tb.sv */
// Self-checking testbench for the multi-stack move engine: pushes, moves and queries with checks.
`timescale 1ns / 1ps

module multi_stack_move_engine_tb;
    import mse_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int MAX_GAP        = 13;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 300;
    // Command code 3 is not a named command; the engine treats it as a query
    localparam logic [CMD_W-1:0] CMD_QUERY_ALIAS = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 cfg_wr_en;
    logic                 cfg_wr_data;

    // Model of the stacks and the mode register
    logic [BYTE_W-1:0] stack_bytes [NUM_STACKS][STACK_DEPTH];
    int                stack_level [NUM_STACKS];
    logic              keep_order_mdl;
    t_rsp              stack_report_q [$];

    int  n_fail;
    int  n_results;
    int  n_push;
    int  n_move;
    int  n_query;
    int  n_underflow;
    int  n_overflow;
    int  n_full_moves;
    int  idle_count;
    int  rx_hold_cycles;
    bit  no_idle;

    multi_stack_move_engine u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int level_of(input int stk);
        return (stk < NUM_STACKS) ? stack_level[stk] : 0;
    endfunction

    // Apply one item to the model and return the report on its destination stack
    function automatic t_rsp apply_stack_op(input logic [CMD_W-1:0] cmd,
                                            input logic [BYTE_W-1:0] item,
                                            input logic [COUNT_W-1:0] cnt,
                                            input logic [IDX_W-1:0] src,
                                            input logic [IDX_W-1:0] dst);
        int   hs;
        int   hd;
        int   from;
        t_err err;
        t_rsp rsp;
        err = ERR_OK;
        if (cmd == CMD_PUSH) begin
            n_push++;
            if (dst >= NUM_STACKS || stack_level[dst] >= STACK_DEPTH) begin
                err = ERR_OVERFLOW;
            end else begin
                stack_bytes[dst][stack_level[dst]] = item;
                stack_level[dst]++;
            end
        end else if (cmd == CMD_MOVE) begin
            n_move++;
            hs = level_of(src);
            if (cnt > hs) begin
                err = ERR_UNDERFLOW;
            end else if (cnt == 0 || src == dst) begin
                err = ERR_OK;
            end else if (dst >= NUM_STACKS || stack_level[dst] + cnt > STACK_DEPTH) begin
                err = ERR_OVERFLOW;
            end else begin
                // Copy the group; source and destination never overlap here
                hd = stack_level[dst];
                for (int i = 0; i < cnt; i++) begin
                    from = keep_order_mdl ? (hs - cnt + i) : (hs - 1 - i);
                    stack_bytes[dst][hd + i] = stack_bytes[src][from];
                end
                stack_level[src] = hs - cnt;
                stack_level[dst] = hd + cnt;
                if (cnt == STACK_DEPTH)
                    n_full_moves++;
            end
        end else begin
            n_query++;
        end
        if (err == ERR_UNDERFLOW)
            n_underflow++;
        if (err == ERR_OVERFLOW)
            n_overflow++;
        hd = level_of(dst);
        rsp.top_item   = (hd > 0) ? stack_bytes[dst][hd - 1] : '0;
        rsp.is_empty   = (hd == 0);
        rsp.error_code = err;
        return rsp;
    endfunction

    // Check each result, then predict each accepted item
    always @(posedge clk) begin : result_monitor
        t_rsp got;
        t_rsp want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got.top_item   = m_tdata[7:0];
                got.is_empty   = m_tdata[8];
                got.error_code = t_err'(m_tdata[10:9]);
                n_results++;
                if (stack_report_q.size() == 0) begin
                    $display("%0t: result with none pending: actual %h", $time, m_tdata);
                    n_fail++;
                end else begin
                    want = stack_report_q.pop_front();
                    if (got.top_item !== want.top_item) begin
                        $display("%0t: top_item expected %h actual %h",
                                 $time, want.top_item, got.top_item);
                        n_fail++;
                    end
                    if (got.is_empty !== want.is_empty) begin
                        $display("%0t: is_empty expected %b actual %b",
                                 $time, want.is_empty, got.is_empty);
                        n_fail++;
                    end
                    if (got.error_code !== want.error_code) begin
                        $display("%0t: error_code expected %0d actual %0d",
                                 $time, want.error_code, got.error_code);
                        n_fail++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                stack_report_q.push_back(apply_stack_op(s_tuser, s_tdata[7:0],
                                                        s_tdata[14:8], s_tdata[18:15],
                                                        s_tdata[22:19]));
        end
    end

    // End the run when nothing moves on either side for too long
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("multi_stack_move_engine test failed");
                $finish;
            end
        end
    end

    // Result side: random stall before each result, plus a long hold when requested
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_hold_cycles > 0) begin
                stall += rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] item,
                             input logic [COUNT_W-1:0] cnt, input logic [IDX_W-1:0] src,
                             input logic [IDX_W-1:0] dst);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, dst, src, cnt, item};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop the input and wait until every pending result has come back
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (stack_report_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_keep_order(input logic mode);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en      <= 1'b0;
        keep_order_mdl = mode;
    endtask

    // Mostly well-formed items: moves sized from the model's stack levels
    task automatic issue_random_item();
        int                 r;
        int                 hs;
        logic [CMD_W-1:0]   cmd;
        logic [BYTE_W-1:0]  item;
        logic [COUNT_W-1:0] cnt;
        logic [IDX_W-1:0]   src;
        logic [IDX_W-1:0]   dst;
        item = BYTE_W'($urandom);
        cnt  = COUNT_W'($urandom);
        src  = IDX_W'($urandom);
        dst  = IDX_W'($urandom);
        r    = $urandom_range(0, 99);
        if (r < 35) begin
            cmd = CMD_PUSH;
        end else if (r < 75) begin
            cmd = CMD_MOVE;
            hs  = stack_level[src];
            r   = $urandom_range(0, 9);
            if (r < 8)
                cnt = (hs > 0) ? COUNT_W'($urandom_range(1, hs)) : '0;
            else if (r == 8)
                cnt = COUNT_W'(hs + 1);
        end else if (r < 95) begin
            cmd = CMD_QUERY;
        end else begin
            cmd = CMD_QUERY_ALIAS;
        end
        send_item(cmd, item, cnt, src, dst);
    endtask

    // Field extremes, every command, no-op and underflow moves, reversing move
    task automatic test_directed();
        send_item(CMD_QUERY, 8'h00, 7'd0, 4'd0, 4'd0);
        send_item(CMD_QUERY_ALIAS, 8'hFF, 7'd127, 4'd15, 4'd15);
        send_item(CMD_PUSH, 8'h00, 7'd0, 4'd0, 4'd0);
        send_item(CMD_PUSH, 8'hFF, 7'd127, 4'd15, 4'd0);
        send_item(CMD_PUSH, 8'hA5, 7'd0, 4'd0, 4'd0);
        send_item(CMD_PUSH, 8'h5A, 7'd0, 4'd0, 4'd15);
        send_item(CMD_MOVE, 8'h00, 7'd0, 4'd0, 4'd1);
        send_item(CMD_MOVE, 8'h00, 7'd2, 4'd0, 4'd0);
        send_item(CMD_MOVE, 8'h00, 7'd4, 4'd0, 4'd1);
        send_item(CMD_MOVE, 8'hFF, 7'd127, 4'd15, 4'd1);
        send_item(CMD_MOVE, 8'h00, 7'd3, 4'd0, 4'd15);
        send_item(CMD_QUERY, 8'h00, 7'd0, 4'd0, 4'd0);
        send_item(CMD_MOVE, 8'h00, 7'd2, 4'd15, 4'd0);
        send_item(CMD_PUSH, 8'h81, 7'd127, 4'd15, 4'd7);
        send_item(CMD_QUERY_ALIAS, 8'h00, 7'd0, 4'd0, 4'd0);
    endtask

    // Order-keeping block moves
    task automatic test_block_order();
        send_item(CMD_PUSH, 8'h11, 7'd0, 4'd0, 4'd8);
        send_item(CMD_PUSH, 8'h22, 7'd0, 4'd0, 4'd8);
        send_item(CMD_PUSH, 8'h33, 7'd0, 4'd0, 4'd8);
        send_item(CMD_MOVE, 8'h00, 7'd3, 4'd8, 4'd9);
        send_item(CMD_MOVE, 8'h00, 7'd2, 4'd9, 4'd8);
        send_item(CMD_QUERY, 8'h00, 7'd0, 4'd0, 4'd9);
        send_item(CMD_PUSH, 8'h44, 7'd0, 4'd0, 4'd9);
        send_item(CMD_MOVE, 8'h00, 7'd2, 4'd9, 4'd15);
    endtask

    // Fill a stack, hit both overflow cases, move a whole stack in each order
    task automatic test_full_stack();
        int need;
        wait_idle();
        need = STACK_DEPTH - stack_level[10];
        repeat (need)
            send_item(CMD_PUSH, 8'($urandom), 7'd0, 4'd0, 4'd10);
        send_item(CMD_PUSH, 8'hEE, 7'd0, 4'd0, 4'd10);
        send_item(CMD_PUSH, 8'h7E, 7'd0, 4'd0, 4'd11);
        send_item(CMD_MOVE, 8'h00, 7'd1, 4'd11, 4'd10);
        send_item(CMD_MOVE, 8'h00, 7'(STACK_DEPTH), 4'd10, 4'd12);
        set_keep_order(1'b0);
        send_item(CMD_MOVE, 8'h00, 7'(STACK_DEPTH), 4'd12, 4'd10);
        send_item(CMD_QUERY, 8'h00, 7'd0, 4'd0, 4'd12);
        send_item(CMD_MOVE, 8'h00, 7'd1, 4'd11, 4'd10);
    endtask

    // Hold off the result side while items keep coming, then drain
    task automatic test_backpressure();
        rx_hold_cycles = HOLD_CYCLES;
        no_idle        = 1'b1;
        repeat (24)
            issue_random_item();
        no_idle = 1'b0;
        wait_idle();
    endtask

    // Random phases, alternating the move order, with stretches of no idling
    task automatic test_random();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_keep_order(ph[0]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 49) == 0)
                    no_idle = ~no_idle;
                issue_random_item();
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        s_tvalid       = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        keep_order_mdl = 1'b0;
        no_idle        = 1'b0;
        rx_hold_cycles = 0;
        idle_count     = 0;
        n_fail         = 0;
        n_results      = 0;
        n_push         = 0;
        n_move         = 0;
        n_query        = 0;
        n_underflow    = 0;
        n_overflow     = 0;
        n_full_moves   = 0;
        foreach (stack_level[s])
            stack_level[s] = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_keep_order(1'b0);
        test_directed();
        set_keep_order(1'b1);
        test_block_order();
        test_full_stack();
        test_backpressure();
        test_random();

        // Let the last results out and watch for strays
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d pushes, %0d moves (%0d full-depth), %0d queries; %0d results",
                 n_push, n_move, n_full_moves, n_query, n_results);
        $display("with %0d underflow and %0d overflow errors, both move orders, a long hold-off",
                 n_underflow, n_overflow);
        if (n_fail == 0) begin
            $display("multi_stack_move_engine test passed");
        end else begin
            $display("multi_stack_move_engine test failed");
        end
        $finish;
    end

endmodule
